// ===== hw/rtl/vrt_pkg.sv =====
// voxel ray traversal package: shared constants, voxel codes, face codes
// and the controller/datapath command and status structs. no dependencies.
`timescale 1ns / 1ps
package vrt_pkg;

    localparam int MAP_WIDTH_DEF  = 16;
    localparam int MAP_HEIGHT_DEF = 16;
    localparam int MAP_DEPTH_DEF  = 16;

    // signed cell index, covers -1 .. 64 for any map size in range
    localparam int CELL_W   = 8;
    localparam int DIR_W    = 16;
    localparam int POS_W    = 16;
    localparam int FRAC_W   = 13;
    localparam int DIV_BITS = 31;
    localparam int BIT_W    = 5;
    localparam int REM_W    = 16;
    localparam int ACC_W    = 44;
    localparam int SIDE_W   = 62;
    localparam int LIMIT_SHIFT = 20;
    localparam int INC_SHIFT   = 12;
    localparam int SAT_SHIFT   = 48;

    // side increment for an axis with zero direction
    localparam logic [SIDE_W-1:0] SAT_INC =
        ((SIDE_W'(1) << SAT_SHIFT) - SIDE_W'(1)) << INC_SHIFT;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [7:0] VOX_AIR   = 8'd0;
    localparam logic [7:0] VOX_FLOOR = 8'd1;
    localparam logic [7:0] VOX_WALL  = 8'd2;
    localparam logic [7:0] VOX_LIGHT = 8'd3;

    localparam logic [1:0] FACE_X = 2'd0;
    localparam logic [1:0] FACE_Y = 2'd1;
    localparam logic [1:0] FACE_Z = 2'd2;

    typedef struct packed {
        logic load;
        logic clr;
        logic wr;
        logic div_step;
        logic step;
        logic emit_hit;
        logic emit_miss;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_cast;
        logic div_last;
        logic stop;
        logic solid;
    } t_stat;

endpackage

// ===== hw/rtl/vrt_ram.sv =====
// generic single write port, single read port ram with registered read.
// no dependencies.
`timescale 1ns / 1ps
module vrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/vrt_ctrl.sv =====
// voxel ray traversal controller: sequences clearing pass, writes,
// reciprocal division and voxel steps. depends on vrt_pkg.
`timescale 1ns / 1ps
module vrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vrt_pkg::t_stat i_stat,
    output vrt_pkg::t_cmd  o_cmd
);
    import vrt_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_STEP  = 3'd4;
    localparam logic [2:0] ST_TEST  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // captured item decides: store a voxel or start a cast
                if (i_stat.is_cast) begin
                    n_state = ST_DIV;
                end else begin
                    o_cmd.wr = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                if (i_stat.stop) begin
                    o_cmd.emit_miss = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (i_stat.solid) begin
                    o_cmd.emit_hit = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_STEP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);
endmodule

// ===== hw/rtl/vrt_dp.sv =====
// voxel ray traversal datapath: item registers, shared bit-serial reciprocal
// divider with running side product, dda step logic and voxel map ram.
// depends on vrt_pkg and vrt_ram.
`timescale 1ns / 1ps
module vrt_dp #(
    parameter int MAP_WIDTH  = vrt_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = vrt_pkg::MAP_HEIGHT_DEF,
    parameter int MAP_DEPTH  = vrt_pkg::MAP_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  vrt_pkg::t_cmd          i_cmd,
    output vrt_pkg::t_stat         o_stat,
    input  logic                   i_operation,
    input  logic [15:0]            i_start_x,
    input  logic [15:0]            i_start_y,
    input  logic [15:0]            i_start_z,
    input  logic signed [15:0]     i_dir_x,
    input  logic signed [15:0]     i_dir_y,
    input  logic signed [15:0]     i_dir_z,
    input  logic [15:0]            i_max_distance,
    input  logic [3:0]             i_voxel_x,
    input  logic [3:0]             i_voxel_y,
    input  logic [3:0]             i_voxel_z,
    input  logic [7:0]             i_voxel_value,
    output logic                   o_valid,
    output logic                   o_hit,
    output logic [3:0]             o_hit_x,
    output logic [3:0]             o_hit_y,
    output logic [3:0]             o_hit_z,
    output logic [3:0]             o_before_x,
    output logic [3:0]             o_before_y,
    output logic [3:0]             o_before_z,
    output logic [1:0]             o_hit_face
);
    import vrt_pkg::*;

    localparam int AXW    = $clog2(MAP_WIDTH);
    localparam int AYW    = $clog2(MAP_HEIGHT);
    localparam int AZW    = $clog2(MAP_DEPTH);
    localparam int ADDR_W = AXW + AYW + AZW;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    // captured item
    logic             r_op;
    logic [POS_W-1:0] r_start [3];
    logic [DIR_W-1:0] r_dir [3];
    logic [15:0]      r_max;
    logic [3:0]       r_vx, r_vy, r_vz;
    logic [7:0]       r_vval;

    // divider
    logic [1:0]          r_axis;
    logic [BIT_W-1:0]    r_bit;
    logic [REM_W-1:0]    r_rem;
    logic [DIV_BITS-2:0] r_q;
    logic [ACC_W-1:0]    r_acc;

    // traversal state
    logic [DIV_BITS-1:0]      r_delta [3];
    logic                     r_dzero [3];
    logic [SIDE_W-1:0]        r_side [3];
    logic signed [CELL_W-1:0] r_cell [3];
    logic signed [CELL_W-1:0] r_prev [3];
    logic [1:0]               r_face;
    logic [ADDR_W-1:0]        r_clr_cnt;

    // result register
    logic       r_valid;
    logic       r_hit;
    logic [3:0] r_hx, r_hy, r_hz, r_bx, r_by, r_bz;
    logic [1:0] r_hface;

    // divider step
    logic [DIR_W-1:0]  dir_a;
    logic [DIR_W-1:0]  mag;
    logic [FRAC_W-1:0] frac;
    logic              dbit;
    logic [REM_W:0]    trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nx;
    logic [ACC_W-1:0]  acc_nx;
    logic [SIDE_W-1:0] sat_side;

    always_comb begin
        dir_a  = r_dir[r_axis];
        mag    = dir_a[DIR_W-1] ? (~dir_a + DIR_W'(1)) : dir_a;
        frac   = dir_a[DIR_W-1] ? {1'b0, r_start[r_axis][11:0]}
                                : FRAC_W'(4096) - {1'b0, r_start[r_axis][11:0]};
        dbit   = (r_bit == BIT_W'(DIV_BITS - 1));
        trial  = {r_rem, dbit};
        ge     = (trial >= {1'b0, mag});
        rem_nx = ge ? REM_W'(trial - {1'b0, mag}) : REM_W'(trial);
        // horner form of frac * delta while quotient bits come out msb first
        acc_nx = {r_acc[ACC_W-2:0], 1'b0} + (ge ? ACC_W'(frac) : ACC_W'(0));
        sat_side = (SIDE_W'(frac) << SAT_SHIFT) - SIDE_W'(frac);
    end

    // dda step
    logic                     lt_xy, lt_xz, lt_yz;
    logic [1:0]               face;
    logic [SIDE_W-1:0]        t_face;
    logic [SIDE_W-1:0]        inc_face;
    logic [SIDE_W-1:0]        limit;
    logic                     over;
    logic                     oob;
    logic signed [CELL_W-1:0] nc [3];
    logic [ADDR_W-1:0]        raddr;

    function automatic logic [SIDE_W-1:0] side_inc(input logic zero,
                                                   input logic [DIV_BITS-1:0] d);
        return zero ? SAT_INC : (SIDE_W'(d) << INC_SHIFT);
    endfunction

    function automatic logic signed [CELL_W-1:0] cell_step(
        input logic signed [CELL_W-1:0] c, input logic neg);
        return neg ? c - CELL_W'(1) : c + CELL_W'(1);
    endfunction

    always_comb begin
        lt_xy = r_side[0] < r_side[1];
        lt_xz = r_side[0] < r_side[2];
        lt_yz = r_side[1] < r_side[2];
        if (lt_xy) begin
            face = lt_xz ? FACE_X : FACE_Z;
        end else begin
            face = lt_yz ? FACE_Y : FACE_Z;
        end
        nc[0] = r_cell[0];
        nc[1] = r_cell[1];
        nc[2] = r_cell[2];
        unique case (face)
            FACE_X: begin
                t_face   = r_side[0];
                inc_face = side_inc(r_dzero[0], r_delta[0]);
                nc[0]    = cell_step(r_cell[0], r_dir[0][DIR_W-1]);
            end
            FACE_Y: begin
                t_face   = r_side[1];
                inc_face = side_inc(r_dzero[1], r_delta[1]);
                nc[1]    = cell_step(r_cell[1], r_dir[1][DIR_W-1]);
            end
            default: begin
                t_face   = r_side[2];
                inc_face = side_inc(r_dzero[2], r_delta[2]);
                nc[2]    = cell_step(r_cell[2], r_dir[2][DIR_W-1]);
            end
        endcase
        limit = SIDE_W'(r_max) << LIMIT_SHIFT;
        over  = t_face > limit;
        oob   = nc[0][CELL_W-1] || (nc[0] >= $signed(CELL_W'(MAP_WIDTH)))
             || nc[1][CELL_W-1] || (nc[1] >= $signed(CELL_W'(MAP_HEIGHT)))
             || nc[2][CELL_W-1] || (nc[2] >= $signed(CELL_W'(MAP_DEPTH)));
        raddr = {nc[0][AXW-1:0], nc[1][AYW-1:0], nc[2][AZW-1:0]};
    end

    // reset contents of the map for the clearing pass
    logic [AXW-1:0]    cx;
    logic [AYW-1:0]    cy;
    logic [AZW-1:0]    cz;
    logic [7:0]        clr_val;
    logic              wr_in_map;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    always_comb begin
        cx = r_clr_cnt[ADDR_W-1 -: AXW];
        cy = r_clr_cnt[AYW+AZW-1 -: AYW];
        cz = r_clr_cnt[AZW-1:0];
        if (cz == AZW'(0)) begin
            clr_val = VOX_FLOOR;
        end else if (cz == AZW'(MAP_DEPTH - 1)) begin
            clr_val = (cx == AXW'(MAP_WIDTH / 2) && cy == AYW'(MAP_HEIGHT / 2))
                    ? VOX_LIGHT : VOX_WALL;
        end else if (cx == AXW'(0) || cx == AXW'(MAP_WIDTH - 1) ||
                     cy == AYW'(0) || cy == AYW'(MAP_HEIGHT - 1)) begin
            clr_val = VOX_WALL;
        end else begin
            clr_val = VOX_AIR;
        end
        wr_in_map = (int'(r_vx) < MAP_WIDTH) && (int'(r_vy) < MAP_HEIGHT)
                 && (int'(r_vz) < MAP_DEPTH);
        ram_we    = i_cmd.clr || (i_cmd.wr && wr_in_map);
        ram_waddr = i_cmd.clr ? r_clr_cnt
                              : {AXW'(r_vx), AYW'(r_vy), AZW'(r_vz)};
        ram_wdata = i_cmd.clr ? clr_val : r_vval;
    end

    vrt_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            r_valid <= i_cmd.emit_hit || i_cmd.emit_miss;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_start[0] <= i_start_x;
            r_start[1] <= i_start_y;
            r_start[2] <= i_start_z;
            r_dir[0]   <= i_dir_x;
            r_dir[1]   <= i_dir_y;
            r_dir[2]   <= i_dir_z;
            r_dzero[0] <= (i_dir_x == '0);
            r_dzero[1] <= (i_dir_y == '0);
            r_dzero[2] <= (i_dir_z == '0);
            r_max      <= i_max_distance;
            r_vx       <= i_voxel_x;
            r_vy       <= i_voxel_y;
            r_vz       <= i_voxel_z;
            r_vval     <= i_voxel_value;
            r_cell[0]  <= $signed({{(CELL_W-4){1'b0}}, i_start_x[15:12]});
            r_cell[1]  <= $signed({{(CELL_W-4){1'b0}}, i_start_y[15:12]});
            r_cell[2]  <= $signed({{(CELL_W-4){1'b0}}, i_start_z[15:12]});
            r_axis     <= 2'd0;
            r_bit      <= BIT_W'(DIV_BITS - 1);
            r_rem      <= '0;
            r_q        <= '0;
            r_acc      <= '0;
        end else if (i_cmd.div_step) begin
            if (r_bit == '0) begin
                r_delta[r_axis] <= {r_q, ge};
                r_side[r_axis]  <= r_dzero[r_axis] ? sat_side : SIDE_W'(acc_nx);
                r_axis          <= r_axis + 2'd1;
                r_bit           <= BIT_W'(DIV_BITS - 1);
                r_rem           <= '0;
                r_q             <= '0;
                r_acc           <= '0;
            end else begin
                r_bit <= r_bit - BIT_W'(1);
                r_rem <= rem_nx;
                r_q   <= {r_q[DIV_BITS-3:0], ge};
                r_acc <= acc_nx;
            end
        end else if (i_cmd.step) begin
            r_prev[0] <= r_cell[0];
            r_prev[1] <= r_cell[1];
            r_prev[2] <= r_cell[2];
            r_cell[0] <= nc[0];
            r_cell[1] <= nc[1];
            r_cell[2] <= nc[2];
            r_face    <= face;
            unique case (face)
                FACE_X:  r_side[0] <= r_side[0] + inc_face;
                FACE_Y:  r_side[1] <= r_side[1] + inc_face;
                default: r_side[2] <= r_side[2] + inc_face;
            endcase
        end

        if (i_cmd.emit_hit) begin
            r_hit   <= 1'b1;
            r_hx    <= r_cell[0][3:0];
            r_hy    <= r_cell[1][3:0];
            r_hz    <= r_cell[2][3:0];
            r_bx    <= r_prev[0][3:0];
            r_by    <= r_prev[1][3:0];
            r_bz    <= r_prev[2][3:0];
            r_hface <= r_face;
        end else if (i_cmd.emit_miss) begin
            r_hit   <= 1'b0;
            r_hx    <= '0;
            r_hy    <= '0;
            r_hz    <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            r_bz    <= '0;
            r_hface <= FACE_X;
        end
    end

    always_comb begin
        o_stat.clr_last = (r_clr_cnt == ADDR_W'(RAM_DEPTH - 1));
        o_stat.is_cast  = (r_op == OP_CAST);
        o_stat.div_last = (r_bit == '0) && (r_axis == 2'd2);
        o_stat.stop     = over || oob;
        o_stat.solid    = (ram_rdata != VOX_AIR);
    end

    assign o_valid    = r_valid;
    assign o_hit      = r_hit;
    assign o_hit_x    = r_hx;
    assign o_hit_y    = r_hy;
    assign o_hit_z    = r_hz;
    assign o_before_x = r_bx;
    assign o_before_y = r_by;
    assign o_before_z = r_bz;
    assign o_hit_face = r_hface;
endmodule

// ===== hw/rtl/voxel_ray_traversal.sv =====
// voxel ray traversal top level: controller plus datapath with voxel map.
// depends on vrt_pkg, vrt_ctrl, vrt_dp and vrt_ram.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low; results come
// out as a one-cycle o_valid strobe that cannot be held off. After reset the
// block runs a clearing pass that loads the floor, ceiling, wall and light
// pattern into the map, one voxel a cycle, over all 2^(clog2(W)+clog2(H)+
// clog2(D)) addresses (4096 for the default 16x16x16 map); busy stays high
// until it ends. A voxel write gives no result. A cast runs the bit-serial
// reciprocal divider (31 quotient bits for each of the three axes) and then
// steps voxel by voxel, each step being a step state and a map read state;
// a miss takes one step more, the step that ends the ray. o_valid rises in
// the cycle after the state that emits the result, when busy has already
// dropped.
module voxel_ray_traversal #(
    parameter int MAP_WIDTH  = vrt_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = vrt_pkg::MAP_HEIGHT_DEF,
    parameter int MAP_DEPTH  = vrt_pkg::MAP_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [15:0]        i_start_x,
    input  logic [15:0]        i_start_y,
    input  logic [15:0]        i_start_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic [15:0]        i_max_distance,
    input  logic [3:0]         i_voxel_x,
    input  logic [3:0]         i_voxel_y,
    input  logic [3:0]         i_voxel_z,
    input  logic [7:0]         i_voxel_value,
    output logic               o_valid,
    output logic               o_hit,
    output logic [3:0]         o_hit_x,
    output logic [3:0]         o_hit_y,
    output logic [3:0]         o_hit_z,
    output logic [3:0]         o_before_x,
    output logic [3:0]         o_before_y,
    output logic [3:0]         o_before_z,
    output logic [1:0]         o_hit_face
);
    import vrt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    vrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    vrt_dp #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .MAP_DEPTH  (MAP_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_start_z      (i_start_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_max_distance (i_max_distance),
        .i_voxel_x      (i_voxel_x),
        .i_voxel_y      (i_voxel_y),
        .i_voxel_z      (i_voxel_z),
        .i_voxel_value  (i_voxel_value),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_hit_x        (o_hit_x),
        .o_hit_y        (o_hit_y),
        .o_hit_z        (o_hit_z),
        .o_before_x     (o_before_x),
        .o_before_y     (o_before_y),
        .o_before_z     (o_before_z),
        .o_hit_face     (o_hit_face)
    );

    // a result only appears once the controller has gone back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    // a miss reports every field as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_x == 4'd0 && o_hit_y == 4'd0 &&
                                 o_hit_z == 4'd0 && o_before_x == 4'd0 &&
                                 o_before_y == 4'd0 && o_before_z == 4'd0 &&
                                 o_hit_face == FACE_X))
        else $error("miss with nonzero fields");

    // consecutive results need at least a new transaction in between
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");
endmodule
